// File: sv/hssad_pkg.sv
// ----------------------------------------------------------------------------
// hssad_pkg
// Shared types, constants and segment helpers for the hall spin/area display.
// ----------------------------------------------------------------------------
package hssad_pkg;

	localparam int DIGITS = 3;

	localparam int SPIN_W  = 16;
	localparam int AREA_W  = 23;
	localparam int SEG_W   = 16;
	localparam int PROD_W  = 32;

	// configuration register indexes
	localparam logic REG_SPIN_AREA    = 1'b0;
	localparam logic REG_DOT_POSITION = 1'b1;

	localparam logic [15:0] SPIN_AREA_RST    = 16'd1885;
	localparam logic [1:0]  DOT_POSITION_RST = 2'd2;

	// input op codes
	localparam logic OP_EDGE    = 1'b0;
	localparam logic OP_TIMEOUT = 1'b1;

	localparam logic [1:0] SENSOR_LAST = 2'd2;
	localparam logic [7:0] ORDER_FULL  = 8'd4;
	localparam logic [7:0] ORDER_START = 8'd1;

	localparam logic [1:0] DOT_NONE = 2'd0;
	localparam logic [15:0] DOT_MASK = 16'h0200;

	// divide by 1000 as (x >> 3) / 125 with a rounded-up reciprocal
	localparam logic [29:0] RECIP_AREA = 30'd549755814;   // ceil(2^36 / 125)
	localparam int          SHIFT_AREA = 36;
	localparam logic [20:0] RECIP_THOU = 21'd1073742;     // ceil(2^27 / 125)
	localparam int          SHIFT_THOU = 27;

	typedef struct packed {
		logic [SPIN_W-1:0] spins;
		logic              added;
	} item_t;

	function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
		logic [SEG_W-1:0] m;
		unique case (digit)
			4'd0: m = 16'h6C22;
			4'd1: m = 16'h4800;
			4'd2: m = 16'h2C21;
			4'd3: m = 16'h6C01;
			4'd4: m = 16'h4803;
			4'd5: m = 16'h6403;
			4'd6: m = 16'h6423;
			4'd7: m = 16'h4C00;
			4'd8: m = 16'h6C23;
			4'd9: m = 16'h6C03;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [SEG_W-1:0] place_mask(input logic [3:0] digit,
		input logic [1:0] place, input logic [1:0] dot);
		logic [SEG_W-1:0] m;
		m = '0;
		if (int'(place) < DIGITS) begin
			m = seg_of(digit);
			if (dot != DOT_NONE && (dot - 2'd1) == place)
				m = m | DOT_MASK;
		end
		return m;
	endfunction

endpackage

// File: sv/hall_sequence_spin_area_display_top.sv
// ----------------------------------------------------------------------------
// hall_sequence_spin_area_display_top
// Hall-sensor spin counter with area value and seven-segment digit masks.
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_stall is low and returns one result word for
// each, through six registers. The stage count comes from the area
// product, the two reciprocal multiplies that divide by 1000 and the digit
// split feeding the output register. Stages collapse bubbles, so input stalls
// only once all six hold words behind a stalled output. Sensor order and spin
// state update in the cycle a word is accepted.
module hall_sequence_spin_area_display_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [1:0]  sensor_id,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] spin_count,
	output logic        spin_added,
	output logic [22:0] area_value,
	output logic [15:0] left_digit_segments,
	output logic [15:0] middle_digit_segments,
	output logic [15:0] right_digit_segments
);

	logic [15:0] spin_area_q;
	logic [1:0] dot_position_q;

	logic rdy_state;
	logic rdy_area;
	logic rdy_digits;
	logic v_s1;
	logic v_s3;
	hssad_pkg::item_t item_s1;
	hssad_pkg::item_t item_s3;
	logic [hssad_pkg::AREA_W-1:0] area_s3;

	assign in_stall = !rdy_state;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spin_area_q <= hssad_pkg::SPIN_AREA_RST;
			dot_position_q <= hssad_pkg::DOT_POSITION_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hssad_pkg::REG_SPIN_AREA:    spin_area_q <= cfg_data;
				hssad_pkg::REG_DOT_POSITION: dot_position_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	hssad_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.sensor_id (sensor_id),
		.rdy       (rdy_state),
		.nxt_rdy   (rdy_area),
		.v_s1      (v_s1),
		.item_s1   (item_s1)
	);

	hssad_area u_area (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (v_s1),
		.item_in   (item_s1),
		.spin_area (spin_area_q),
		.rdy       (rdy_area),
		.nxt_rdy   (rdy_digits),
		.v_s3      (v_s3),
		.item_s3   (item_s3),
		.area_s3   (area_s3)
	);

	hssad_digits u_digits (
		.clk                   (clk),
		.arst_n                (arst_n),
		.v_in                  (v_s3),
		.item_in               (item_s3),
		.area_in               (area_s3),
		.dot_position          (dot_position_q),
		.rdy                   (rdy_digits),
		.out_stall             (out_stall),
		.out_valid             (out_valid),
		.spin_count            (spin_count),
		.spin_added            (spin_added),
		.area_value            (area_value),
		.left_digit_segments   (left_digit_segments),
		.middle_digit_segments (middle_digit_segments),
		.right_digit_segments  (right_digit_segments)
	);

	// input can only back up once the output register holds a word
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output register");

	// no spins means no area
	a_zero_spins_zero_area: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && spin_count == 16'd0) |-> (area_value == 23'd0))
		else $error("nonzero area with zero spins");

endmodule

// File: sv/hssad_state.sv
// ----------------------------------------------------------------------------
// hssad_state
// Sensor order tracking and spin counting; first pipeline stage.
// ----------------------------------------------------------------------------
module hssad_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 op,
	input  logic [1:0]           sensor_id,
	output logic                 rdy,
	input  logic                 nxt_rdy,
	output logic                 v_s1,
	output hssad_pkg::item_t     item_s1
);

	logic [1:0] last_sensor_q;
	logic [7:0] order_count_q;
	logic [15:0] spins_q;

	logic [1:0] expect_id;
	logic [1:0] last_sensor_d;
	logic [7:0] order_count_d;
	logic [15:0] spins_d;
	logic added_d;
	logic accept;

	assign rdy = !v_s1 || nxt_rdy;
	assign accept = in_valid && rdy;

	always_comb begin
		expect_id = (last_sensor_q == hssad_pkg::SENSOR_LAST) ? 2'd0 :
			(last_sensor_q == 2'd3) ? 2'd1 : last_sensor_q + 2'd1;
		last_sensor_d = last_sensor_q;
		order_count_d = order_count_q;
		spins_d = spins_q;
		added_d = 1'b0;
		if (op == hssad_pkg::OP_EDGE) begin
			// sensor three does not exist and never matches
			if (sensor_id != 2'd3 && sensor_id == expect_id) begin
				order_count_d = order_count_q + 8'd1;
				last_sensor_d = sensor_id;
			end
		end else if (order_count_q == hssad_pkg::ORDER_FULL) begin
			order_count_d = hssad_pkg::ORDER_START;
			spins_d = spins_q + 16'd1;
			added_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sensor_q <= hssad_pkg::SENSOR_LAST;
			order_count_q <= '0;
			spins_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				last_sensor_q <= last_sensor_d;
				order_count_q <= order_count_d;
				spins_q <= spins_d;
			end
			if (rdy)
				v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.spins <= spins_d;
			item_s1.added <= added_d;
		end
	end

endmodule

// File: sv/hssad_area.sv
// ----------------------------------------------------------------------------
// hssad_area
// Area product and reciprocal divide by 1000; stages two and three.
// ----------------------------------------------------------------------------
module hssad_area (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              v_in,
	input  hssad_pkg::item_t                  item_in,
	input  logic [15:0]                       spin_area,
	output logic                              rdy,
	input  logic                              nxt_rdy,
	output logic                              v_s3,
	output hssad_pkg::item_t                  item_s3,
	output logic [hssad_pkg::AREA_W-1:0]      area_s3
);

	logic v_s2;
	logic en2;
	logic en3;
	hssad_pkg::item_t item_s2;
	logic [hssad_pkg::PROD_W-1:0] prod_s2;
	logic [58:0] quot_full;

	assign en3 = !v_s3 || nxt_rdy;
	assign en2 = !v_s2 || en3;
	assign rdy = en2;

	assign quot_full = prod_s2[31:3] * hssad_pkg::RECIP_AREA;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en2)
				v_s2 <= v_in;
			if (en3)
				v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_in) begin
			item_s2 <= item_in;
			prod_s2 <= item_in.spins * spin_area;
		end
		if (en3 && v_s2) begin
			item_s3 <= item_s2;
			area_s3 <= quot_full[58:hssad_pkg::SHIFT_AREA];
		end
	end

endmodule

// File: sv/hssad_digits.sv
// ----------------------------------------------------------------------------
// hssad_digits
// Low three decimal digits of the area and segment masks; stages four to six.
// ----------------------------------------------------------------------------
module hssad_digits (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              v_in,
	input  hssad_pkg::item_t                  item_in,
	input  logic [hssad_pkg::AREA_W-1:0]      area_in,
	input  logic [1:0]                        dot_position,
	output logic                              rdy,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic [15:0]                       spin_count,
	output logic                              spin_added,
	output logic [22:0]                       area_value,
	output logic [15:0]                       left_digit_segments,
	output logic [15:0]                       middle_digit_segments,
	output logic [15:0]                       right_digit_segments
);

	logic v_s4;
	logic v_s5;
	logic en4;
	logic en5;
	logic en6;
	hssad_pkg::item_t item_s4;
	hssad_pkg::item_t item_s5;
	logic [22:0] area_s4;
	logic [22:0] area_s5;
	logic [13:0] thou_s4;
	logic [9:0] low_s5;

	logic [40:0] thou_full;
	logic [20:0] thou_x125;
	logic [19:0] rem125;
	logic [15:0] h_mul;
	logic [3:0] hund;
	logic [9:0] rem100;
	logic [13:0] t_mul;
	logic [3:0] tens;
	logic [7:0] tens_x10;
	logic [3:0] units;

	assign en6 = !out_valid || !out_stall;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign rdy = en4;

	assign thou_full = area_in[22:3] * hssad_pkg::RECIP_THOU;

	// area mod 1000 = ((area >> 3) mod 125) * 8 + low three bits
	assign thou_x125 = {7'd0, thou_s4} * 21'd125;
	assign rem125 = area_s4[22:3] - thou_x125[19:0];

	// hundreds by x*41 >> 12 and tens by x*103 >> 10, exact below 1000 and 100
	assign h_mul = {6'd0, low_s5} * 16'd41;
	assign hund = h_mul[15:12];
	assign rem100 = low_s5 - ({6'd0, hund} * 10'd100);
	assign t_mul = {7'd0, rem100[6:0]} * 14'd103;
	assign tens = t_mul[13:10];
	assign tens_x10 = {4'd0, tens} * 8'd10;
	assign units = rem100[3:0] - tens_x10[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en4)
				v_s4 <= v_in;
			if (en5)
				v_s5 <= v_s4;
			if (en6)
				out_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_in) begin
			item_s4 <= item_in;
			area_s4 <= area_in;
			thou_s4 <= thou_full[40:hssad_pkg::SHIFT_THOU];
		end
		if (en5 && v_s4) begin
			item_s5 <= item_s4;
			area_s5 <= area_s4;
			low_s5 <= {rem125[6:0], area_s4[2:0]};
		end
		if (en6 && v_s5) begin
			spin_count <= item_s5.spins;
			spin_added <= item_s5.added;
			area_value <= area_s5;
			left_digit_segments <= hssad_pkg::place_mask(hund, 2'd2, dot_position);
			middle_digit_segments <= hssad_pkg::place_mask(tens, 2'd1, dot_position);
			right_digit_segments <= hssad_pkg::place_mask(units, 2'd0, dot_position);
		end
	end

endmodule
